@@ hdl/ardte_pkg.sv @@
// Shared character constants and widths for the altitude row delta text encoder.
package ardte_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CHAR_W   = 7;
	localparam int unsigned CHUNK_W  = 5;

	localparam logic [CHAR_W-1:0] CHAR_OFFSET    = 7'h3f;
	localparam logic [CHAR_W-1:0] CHAR_CONT      = 7'h20;
	localparam logic [CHAR_W-1:0] CHAR_COLON     = 7'h3a;
	localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 7'h5c;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [CHAR_W-1:0]   char_t;

endpackage

@@ hdl/altitude_row_delta_text_encoder.sv @@
// Top level: delta, zero-run and zigzag text encoder for rows of altitude samples.
//
// Input beats arrive on the s_ group: tdata[15:0] is a signed altitude sample and
// tlast marks the last sample of a row. Output beats leave on the m_ group, one
// ASCII character per beat: tdata[6:0] is the character, tuser flags the last
// character caused by one sample, and tlast flags the last character of a row.
// A sample may cause no character at all (a zero difference inside a run).
//
// With the default ROW_LENGTH, one sample produces between zero and six
// characters. A single chunk unit (compare against 32, add the 0x3f offset,
// shift right by five) produces one character per cycle under a small
// sequencer while the output register can take it, and s_tready stays low
// while characters remain. The first character is written into the output
// register after the input beat is taken, once that register is free. The next
// sample is taken as soon as the last character of the current one is in the
// output register, even if that character is still waiting.
//
// When the receiver holds m_tready low, the output register keeps its beat and
// the sequencer waits. Reset clears the previous sample, the run count and all
// pending characters.
module altitude_row_delta_text_encoder #(
	parameter int unsigned ROW_LENGTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [15:0] s_tdata,  // [15:0] altitude
	input  logic       s_tlast,   // end_of_row
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] code_char, [7] zero
	output logic [0:0] m_tuser,   // [0] last_of_item
	output logic       m_tlast    // last_of_row
);

	localparam int unsigned RUN_W = $clog2(ROW_LENGTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_COLON = 2'd1;
	localparam logic [1:0] ST_VAL   = 2'd2;
	localparam logic [1:0] ST_DUP   = 2'd3;

	logic [1:0]         state_q;
	ardte_pkg::sample_t prev_q;
	logic [RUN_W-1:0]   run_q;
	ardte_pkg::sample_t val_q;
	ardte_pkg::sample_t zz_q;
	logic               zz_pend_q;
	logic               cnt_pend_q;
	logic               eor_q;

	logic               obuf_valid_q;
	ardte_pkg::char_t   obuf_char_q;
	logic               obuf_item_q;
	logic               obuf_row_q;

	// Accept-side arithmetic.
	logic               accept;
	ardte_pkg::sample_t diff;
	ardte_pkg::sample_t zz;
	logic               diff_zero;
	logic [RUN_W-1:0]   run_inc;
	logic               cnt_emit;
	logic [RUN_W-1:0]   cnt_val;

	// Chunk unit and sequencer.
	logic               adv;
	ardte_pkg::char_t   ch;
	ardte_pkg::char_t   tail_char;
	logic               seg_fin;
	logic               cont;
	logic               last_char;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign diff      = s_tdata - prev_q;
	assign diff_zero = (diff == '0);
	assign zz        = diff[15] ? ~{diff[14:0], 1'b0} : {diff[14:0], 1'b0};
	assign run_inc   = (run_q < RUN_W'(ROW_LENGTH)) ? run_q + RUN_W'(1) : run_q;
	assign cnt_emit  = diff_zero ? s_tlast : (run_q != '0);
	assign cnt_val   = diff_zero ? run_inc : run_q;

	assign adv = (state_q != ST_IDLE) && (!obuf_valid_q || m_tready);

	assign tail_char = ardte_pkg::CHAR_OFFSET + ardte_pkg::char_t'(val_q[4:0]);

	always_comb begin
		ch      = ardte_pkg::CHAR_BACKSLASH;
		seg_fin = 1'b0;
		cont    = 1'b0;
		case (state_q)
			ST_COLON: begin
				ch      = ardte_pkg::CHAR_COLON;
				seg_fin = 1'b1;
				cont    = cnt_pend_q;
			end
			ST_VAL: begin
				if (val_q[15:5] != '0) begin
					ch = ardte_pkg::CHAR_OFFSET
						+ (ardte_pkg::CHAR_CONT | ardte_pkg::char_t'(val_q[4:0]));
				end else begin
					ch      = tail_char;
					seg_fin = (tail_char != ardte_pkg::CHAR_BACKSLASH);
					cont    = zz_pend_q;
				end
			end
			ST_DUP: begin
				ch      = ardte_pkg::CHAR_BACKSLASH;
				seg_fin = 1'b1;
				cont    = zz_pend_q;
			end
			default: begin
				ch      = ardte_pkg::CHAR_BACKSLASH;
				seg_fin = 1'b0;
				cont    = 1'b0;
			end
		endcase
	end

	assign last_char = seg_fin && !cont;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prev_q     <= '0;
			run_q      <= '0;
			zz_pend_q  <= 1'b0;
			cnt_pend_q <= 1'b0;
			eor_q      <= 1'b0;
		end else if (accept) begin
			prev_q     <= s_tlast ? '0 : s_tdata;
			eor_q      <= s_tlast;
			cnt_pend_q <= s_tlast;
			zz_pend_q  <= !diff_zero && cnt_emit;
			if (s_tlast || !diff_zero) begin
				run_q <= '0;
			end else begin
				run_q <= run_inc;
			end
			if (diff_zero) begin
				if (run_q == '0) begin
					state_q <= ST_COLON;
				end else if (s_tlast) begin
					state_q <= ST_VAL;
				end else begin
					state_q <= ST_IDLE;
				end
			end else begin
				state_q <= ST_VAL;
			end
		end else if (adv) begin
			if (seg_fin) begin
				if (state_q == ST_COLON) begin
					state_q    <= cnt_pend_q ? ST_VAL : ST_IDLE;
					cnt_pend_q <= 1'b0;
				end else begin
					state_q   <= zz_pend_q ? ST_VAL : ST_IDLE;
					zz_pend_q <= 1'b0;
				end
			end else if (state_q == ST_VAL && val_q[15:5] == '0) begin
				// Final chunk came out as a backslash; it is sent twice.
				state_q <= ST_DUP;
			end
		end
	end

	// Value shifter: loaded at accept, shifted by chunks, reloaded for zigzag.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= cnt_emit ? ardte_pkg::sample_t'(cnt_val) : zz;
			zz_q  <= zz;
		end else if (adv) begin
			if (seg_fin && state_q != ST_COLON && zz_pend_q) begin
				val_q <= zz_q;
			end else if (state_q == ST_VAL) begin
				val_q <= val_q >> ardte_pkg::CHUNK_W;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_valid_q <= 1'b0;
		end else if (adv) begin
			obuf_valid_q <= 1'b1;
		end else if (m_tready) begin
			obuf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			obuf_char_q <= ch;
			obuf_item_q <= last_char;
			obuf_row_q  <= last_char && eor_q;
		end
	end

	assign m_tvalid = obuf_valid_q;
	assign m_tdata  = {1'b0, obuf_char_q};
	assign m_tuser  = obuf_item_q;
	assign m_tlast  = obuf_row_q;

endmodule

@@ hdl/ardte_checker.sv @@
// Port-level checks for the altitude row delta text encoder, bound to the top level.
module ardte_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [15:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [0:0] m_tuser,
	input logic       m_tlast
);

	// A stalled output beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output beat changed while stalled");

	// Every character is printable text: a colon or an offset chunk.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7] == 1'b0 && m_tdata[6:0] >= ardte_pkg::CHAR_COLON
			&& m_tdata[6:0] != 7'h7f)
		else $error("character out of range");

	// The end of a row is always also the end of the sample's characters.
	a_row_is_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("row end without item end");

	// While a sample still owes characters, no new sample is taken.
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !s_tready)
		else $error("input ready in the middle of a sample");

	// A taken character that is not the last of its sample is followed at once.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tuser[0] |=> m_tvalid)
		else $error("gap inside the characters of one sample");

endmodule

bind altitude_row_delta_text_encoder ardte_checker u_ardte_checker (.*);
